>>> hdl/ordered_list_engine_defines.svh
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ole_pkg.sv
`timescale 1ns / 1ps

package ole_pkg;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_AT    = 3'd1,
		OP_REM_FRONT = 3'd2,
		OP_REM_AT    = 3'd3,
		OP_REM_VAL   = 3'd4,
		OP_FIND      = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT_UP,
		ST_INS_WR,
		ST_SHIFT_DN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       status;
		logic       hit;
		logic [5:0] found_position;
		logic [6:0] entry_count;
	} res_t;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;

endpackage

>>> hdl/ordered_list_engine.sv
`timescale 1ns / 1ps

// Bounded ordered list of CAPACITY signed 32-bit entries held in one synchronous memory with
// one read and one write port. One transaction in gives one transaction out. The engine works
// on one item at a time. It loads a result into the output register only once that register is
// free, and takes the next item in the cycle after. Entries are moved through the memory one per
// cycle. Insert at a position below count shifts the entries from there up, and insert at the
// tail moves none. Remove at a position below the last entry shifts the later entries down, and
// removing the last entry moves none. Find and remove value read one entry per cycle from the
// front; a search stops at the first match, and a miss reads the whole list. Errors and no-ops
// move no entries.
module ordered_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // operation[2:0], value[34:3], position[41:35], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[0], hit[1], found_position[7:2],
	                               // entry_count[14:8], zero pad
);

	import ole_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic          slot_free;
	logic          res_valid;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;
	logic          m_tvalid_q;
	logic [15:0]   m_tdata_q;

	ole_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tdata[2:0]),
		.in_value  (s_tdata[34:3]),
		.in_pos    (s_tdata[41:35]),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ole_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign slot_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= {1'b0, res.entry_count, res.found_position, res.hit, res.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hdl/ole_store.sv
`timescale 1ns / 1ps

module ole_store #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/ole_ctrl.sv
`timescale 1ns / 1ps

module ole_ctrl #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ole_pkg::OP_W-1:0]    in_op,
	input  logic [ole_pkg::VALUE_W-1:0] in_value,
	input  logic [ole_pkg::POS_W-1:0]   in_pos,
	input  logic                        slot_free,
	output logic                        res_valid,
	output ole_pkg::res_t               res,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [31:0]                 mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [31:0]                 mem_rdata
);

	import ole_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	state_t        state_q, state_d;
	op_t           op_q, op_d;
	logic [31:0]   val_q, val_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] rp_q, rp_d;
	logic          status_q, status_d;
	logic          hit_q, hit_d;
	logic [AW-1:0] where_q, where_d;

	// Registers behind the memory read port: a pending move write or
	// a pending search compare.
	logic          mv_vld_s1, mv_vld_d;
	logic [AW-1:0] mv_dst_s1, mv_dst_d;
	logic          sr_vld_s1, sr_vld_d;
	logic [AW-1:0] sr_addr_s1, sr_addr_d;

	logic [XW-1:0] pos_x, cnt_x;
	logic          ins_wr;
	logic          match;

	assign pos_x = XW'(in_pos);
	assign cnt_x = XW'(cnt_q);
	assign match = sr_vld_s1 && (mem_rdata == val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			mv_vld_s1 <= 1'b0;
			sr_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			mv_vld_s1 <= mv_vld_d;
			sr_vld_s1 <= sr_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		val_q      <= val_d;
		pos_q      <= pos_d;
		rp_q       <= rp_d;
		status_q   <= status_d;
		hit_q      <= hit_d;
		where_q    <= where_d;
		mv_dst_s1  <= mv_dst_d;
		sr_addr_s1 <= sr_addr_d;
	end

	always_comb begin
		logic [XW-1:0] p_x;
		state_d   = state_q;
		op_d      = op_q;
		val_d     = val_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		rp_d      = rp_q;
		status_d  = status_q;
		hit_d     = hit_q;
		where_d   = where_q;
		mv_vld_d  = 1'b0;
		mv_dst_d  = mv_dst_s1;
		sr_vld_d  = 1'b0;
		sr_addr_d = sr_addr_s1;
		mem_re    = 1'b0;
		mem_raddr = rp_q[AW-1:0];
		ins_wr    = 1'b0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		p_x       = '0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d     = op_t'(in_op);
					val_d    = in_value;
					status_d = 1'b0;
					hit_d    = 1'b0;
					where_d  = '0;
					unique case (op_t'(in_op))
						OP_INS_FRONT, OP_INS_AT: begin
							p_x = (op_t'(in_op) == OP_INS_FRONT) ? '0 : pos_x;
							if (cnt_x == XW'(CAPACITY) || p_x > cnt_x) begin
								status_d = 1'b1;
								state_d  = ST_DONE;
							end else begin
								pos_d = AW'(p_x);
								if (p_x == cnt_x) begin
									state_d = ST_INS_WR;
								end else begin
									rp_d    = cnt_q - CW'(1);
									state_d = ST_SHIFT_UP;
								end
							end
						end
						OP_REM_FRONT, OP_REM_AT: begin
							p_x = (op_t'(in_op) == OP_REM_FRONT) ? '0 : pos_x;
							if (p_x >= cnt_x) begin
								// Removing from an empty list at the front is a quiet no-op.
								status_d = (op_t'(in_op) == OP_REM_AT);
								state_d  = ST_DONE;
							end else begin
								pos_d = AW'(p_x);
								if (p_x + XW'(1) == cnt_x) begin
									cnt_d   = cnt_q - CW'(1);
									state_d = ST_DONE;
								end else begin
									rp_d    = CW'(p_x + XW'(1));
									state_d = ST_SHIFT_DN;
								end
							end
						end
						OP_REM_VAL, OP_FIND: begin
							rp_d    = '0;
							state_d = ST_SEARCH;
						end
						default: begin
							status_d = 1'b1;
							state_d  = ST_DONE;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				priority if (match) begin
					hit_d   = 1'b1;
					where_d = sr_addr_s1;
					if (op_q == OP_FIND) begin
						state_d = ST_DONE;
					end else if (CW'(sr_addr_s1) + CW'(1) == cnt_q) begin
						cnt_d   = cnt_q - CW'(1);
						state_d = ST_DONE;
					end else begin
						pos_d   = sr_addr_s1;
						rp_d    = CW'(sr_addr_s1) + CW'(1);
						state_d = ST_SHIFT_DN;
					end
				end else if (rp_q < cnt_q) begin
					mem_re    = 1'b1;
					sr_vld_d  = 1'b1;
					sr_addr_d = rp_q[AW-1:0];
					rp_d      = rp_q + CW'(1);
				end else if (!sr_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT_UP: begin
				mem_re   = 1'b1;
				mv_vld_d = 1'b1;
				mv_dst_d = rp_q[AW-1:0] + AW'(1);
				if (rp_q == CW'(pos_q)) begin
					state_d = ST_INS_WR;
				end else begin
					rp_d = rp_q - CW'(1);
				end
			end
			ST_INS_WR: begin
				// The last move of the shift still owns the write port, so the insert write waits for it.
				if (!mv_vld_s1) begin
					ins_wr  = 1'b1;
					cnt_d   = cnt_q + CW'(1);
					state_d = ST_DONE;
				end
			end
			ST_SHIFT_DN: begin
				mem_re   = 1'b1;
				mv_vld_d = 1'b1;
				mv_dst_d = rp_q[AW-1:0] - AW'(1);
				if (rp_q == cnt_q - CW'(1)) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = ST_DONE;
				end else begin
					rp_d = rp_q + CW'(1);
				end
			end
			ST_DONE: begin
				if (!mv_vld_s1 && slot_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (mv_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = mv_dst_s1;
			mem_wdata = mem_rdata;
		end else begin
			mem_we    = ins_wr;
			mem_waddr = pos_q;
			mem_wdata = val_q;
		end
	end

	assign res.status         = status_q;
	assign res.hit            = hit_q;
	assign res.found_position = 6'(where_q);
	assign res.entry_count    = 7'(cnt_q);

endmodule

>>> hdl/ole_checker.sv
`timescale 1ns / 1ps

`include "ordered_list_engine_defines.svh"

module ole_checker #(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic       out_stall;
	logic [5:0] found_pos;
	logic [6:0] count_out;
	logic       count_ok;

	assign out_stall = m_tvalid && !m_tready;
	assign found_pos = m_tdata[7:2];
	assign count_out = m_tdata[14:8];
	assign count_ok  = (CAPACITY > 127) || (int'(count_out) <= CAPACITY);

	// A stalled result transaction must hold.
	`OLE_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

	// The engine works on one item at a time.
	`OLE_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// An error never comes with a match.
	`OLE_ASSERT_NOW(a_err_no_hit, m_tvalid, !(m_tdata[0] && m_tdata[1]), "error and hit together")

	// Without a match the position reads zero.
	`OLE_ASSERT_NOW(a_miss_pos_zero, m_tvalid && !m_tdata[1], found_pos == 6'd0, "stray position")

	// The reported count never exceeds the capacity.
	`OLE_ASSERT_NOW(a_count_bound, m_tvalid, count_ok, "count above capacity")

endmodule

bind ordered_list_engine ole_checker #(
	.CAPACITY(CAPACITY)
) u_ole_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> verif/ordered_list_engine_tb.sv
`timescale 1ns / 1ps

module ordered_list_engine_tb;
	import ole_pkg::*;

	localparam int LIST_DEPTH = 64;
	// Codes that the block does not define; it must refuse them with an error.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
	localparam int MAX_PRINTS = 100;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_PATTERN
	} ready_mode_t;

	typedef struct {
		res_t        res;
		int unsigned item_no;
		logic [2:0]  op;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // operation[2:0], value[34:3], position[41:35], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // status[0], hit[1], found_position[7:2],
	                             // entry_count[14:8], zero pad

	// Mirror of the list contents as the block should hold them.
	logic [31:0] mirror_entries [LIST_DEPTH];
	int          mirror_len = 0;

	list_result_t pending_results [$];
	int unsigned  items_sent = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  burst_left = 0;

	ready_mode_t ready_mode = RDY_ALWAYS;
	int unsigned ready_left = 0;
	int unsigned ready_phase = 0;

	ordered_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS) begin
			$display("MISMATCH @%0t: %s", $realtime, what);
		end
	endtask

	// Applies one operation to the mirror and returns the result it must produce.
	function automatic res_t predict_list_op(input logic [2:0] op, input logic [31:0] value,
			input logic [6:0] pos);
		res_t r;
		int   p;
		int   i;
		int   match_pos;
		r = '0;
		match_pos = -1;
		if (op == OP_REM_VAL || op == OP_FIND) begin
			for (i = 0; i < mirror_len; i++) begin
				if (match_pos < 0 && mirror_entries[i] == value) begin
					match_pos = i;
				end
			end
		end
		case (op)
			OP_INS_FRONT, OP_INS_AT: begin
				p = (op == OP_INS_FRONT) ? 0 : int'(pos);
				if (mirror_len >= LIST_DEPTH || p > mirror_len) begin
					r.status = 1'b1;
				end else begin
					for (i = mirror_len; i > p; i--) begin
						mirror_entries[i] = mirror_entries[i - 1];
					end
					mirror_entries[p] = value;
					mirror_len++;
				end
			end
			OP_REM_FRONT, OP_REM_AT: begin
				p = (op == OP_REM_FRONT) ? 0 : int'(pos);
				if (p >= mirror_len) begin
					// Removing the front of an empty list is a silent no-op.
					r.status = (op == OP_REM_AT);
				end else begin
					for (i = p; i + 1 < mirror_len; i++) begin
						mirror_entries[i] = mirror_entries[i + 1];
					end
					mirror_len--;
				end
			end
			OP_REM_VAL, OP_FIND: begin
				if (match_pos >= 0) begin
					r.hit = 1'b1;
					r.found_position = match_pos[5:0];
					if (op == OP_REM_VAL) begin
						for (i = match_pos; i + 1 < mirror_len; i++) begin
							mirror_entries[i] = mirror_entries[i + 1];
						end
						mirror_len--;
					end
				end
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		r.entry_count = mirror_len[6:0];
		return r;
	endfunction

	task automatic send_list_op(input logic [2:0] op, input logic [31:0] value,
			input logic [6:0] pos);
		list_result_t want;
		int unsigned  gap;
		s_tdata  <= {6'd0, pos, value, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		want.res = predict_list_op(op, value, pos);
		want.item_no = items_sent;
		want.op = op;
		pending_results.push_back(want);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 80) : $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			4, 5, 6, 7, 8: return $urandom;
			default: return 32'($urandom_range(0, 15)) - 32'd8;
		endcase
	endfunction

	// Mostly a position in 0..valid_max; now and then the first bad one or beyond.
	function automatic logic [6:0] pick_position(input int valid_max);
		int bad_lo;
		bad_lo = valid_max + 1;
		if (valid_max >= 0 && $urandom_range(0, 99) < 85) begin
			return 7'($urandom_range(0, valid_max));
		end
		case ($urandom_range(0, 3))
			0:       return 7'(bad_lo);
			1:       return 7'd127;
			default: return 7'($urandom_range(bad_lo, 127));
		endcase
	endfunction

	// Values of searches and removals mostly come from the list itself so they hit.
	function automatic logic [31:0] pick_search_value();
		if (mirror_len > 0 && $urandom_range(0, 9) < 7) begin
			return mirror_entries[$urandom_range(0, mirror_len - 1)];
		end
		return pick_value();
	endfunction

	task automatic send_random_insert();
		if ($urandom_range(0, 2) == 0) begin
			send_list_op(OP_INS_FRONT, pick_value(), 7'($urandom_range(0, 127)));
		end else begin
			send_list_op(OP_INS_AT, pick_value(), pick_position(mirror_len));
		end
	endtask

	task automatic send_random_remove();
		case ($urandom_range(0, 2))
			0:       send_list_op(OP_REM_FRONT, $urandom, 7'($urandom_range(0, 127)));
			1:       send_list_op(OP_REM_AT, $urandom, pick_position(mirror_len - 1));
			default: send_list_op(OP_REM_VAL, pick_search_value(), 7'($urandom_range(0, 127)));
		endcase
	endtask

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			ready_left <= $urandom_range(20, 300);
		end else begin
			ready_left <= ready_left - 1;
		end
		ready_phase <= ready_phase + 1;
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RDY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default:    m_tready <= ((ready_phase % 7) < 3);
		endcase
	end

	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result transaction 0x%04h with no item pending",
					m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.res.status) begin
					report_mismatch($sformatf("item %0d op %0d: status %b, want %b",
						want.item_no, want.op, m_tdata[0], want.res.status));
				end
				if (m_tdata[1] !== want.res.hit) begin
					report_mismatch($sformatf("item %0d op %0d: hit %b, want %b",
						want.item_no, want.op, m_tdata[1], want.res.hit));
				end
				if (m_tdata[7:2] !== want.res.found_position) begin
					report_mismatch($sformatf("item %0d op %0d: found_position %0d, want %0d",
						want.item_no, want.op, m_tdata[7:2], want.res.found_position));
				end
				if (m_tdata[14:8] !== want.res.entry_count) begin
					report_mismatch($sformatf("item %0d op %0d: entry_count %0d, want %0d",
						want.item_no, want.op, m_tdata[14:8], want.res.entry_count));
				end
			end
		end
	end

	// Hand-picked corners on a short list: empty cases, bad positions, extreme values,
	// duplicates, spare codes.
	task automatic test_directed_corners();
		send_list_op(OP_REM_FRONT, 32'h0000_0000, 7'd0);
		send_list_op(OP_REM_AT, 32'h0000_0000, 7'd0);
		send_list_op(OP_FIND, 32'h0000_0000, 7'd0);
		send_list_op(OP_REM_VAL, 32'h0000_0005, 7'd0);
		send_list_op(OP_INS_AT, 32'h1234_5678, 7'd1);
		send_list_op(OP_INS_AT, 32'h8000_0000, 7'd0);
		send_list_op(OP_INS_FRONT, 32'h7FFF_FFFF, 7'd127);
		send_list_op(OP_INS_AT, 32'hFFFF_FFFF, 7'd2);
		send_list_op(OP_INS_AT, 32'h0000_0001, 7'd127);
		send_list_op(OP_REM_AT, 32'h0000_0000, 7'd3);
		send_list_op(OP_REM_AT, 32'hFFFF_FFFF, 7'd127);
		send_list_op(OP_FIND, 32'h8000_0000, 7'd0);
		send_list_op(OP_FIND, 32'hFFFF_FFFF, 7'd127);
		send_list_op(OP_INS_AT, 32'hFFFF_FFFF, 7'd1);
		send_list_op(OP_FIND, 32'hFFFF_FFFF, 7'd0);
		send_list_op(OP_REM_VAL, 32'hFFFF_FFFF, 7'd0);
		send_list_op(OP_SPARE_6, 32'hFFFF_FFFF, 7'd0);
		send_list_op(OP_SPARE_7, 32'h0000_0000, 7'd127);
		send_list_op(OP_REM_AT, 32'h0000_0000, 7'd2);
		send_list_op(OP_REM_VAL, 32'h7FFF_FFFF, 7'd0);
		send_list_op(OP_REM_FRONT, 32'hFFFF_FFFF, 7'd127);
		send_list_op(OP_REM_FRONT, 32'h0000_0000, 7'd0);
		send_list_op(OP_FIND, 32'h7FFF_FFFF, 7'd0);
	endtask

	// Mostly legal operations on a list whose length wanders; a few raw items.
	task automatic test_random_mixed(input int unsigned n_items);
		int unsigned k;
		int unsigned pick;
		int unsigned insert_pct;
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			insert_pct = (mirror_len < 8) ? 60 : (mirror_len > 56) ? 20 : 40;
			if (pick < 5) begin
				send_list_op(3'($urandom_range(0, 7)), $urandom, 7'($urandom_range(0, 127)));
			end else if ($urandom_range(0, 99) < insert_pct) begin
				send_random_insert();
			end else if ($urandom_range(0, 3) == 0) begin
				send_list_op(OP_FIND, pick_search_value(), 7'($urandom_range(0, 127)));
			end else begin
				send_random_remove();
			end
		end
	endtask

	// Fills the list to capacity, works the full-store refusals and the last position,
	// then drains it back to empty.
	task automatic test_fill_and_drain();
		logic [31:0] tail_value;
		while (mirror_len < LIST_DEPTH) begin
			send_random_insert();
		end
		send_list_op(OP_INS_FRONT, pick_value(), 7'd0);
		send_list_op(OP_INS_AT, pick_value(), 7'd64);
		send_list_op(OP_INS_AT, pick_value(), 7'($urandom_range(0, 63)));
		send_list_op(OP_REM_AT, $urandom, 7'd63);
		tail_value = 32'h5A5A_0000 | ($urandom & 32'h0000_FFFF);
		send_list_op(OP_INS_AT, tail_value, 7'd63);
		send_list_op(OP_FIND, tail_value, 7'($urandom_range(0, 127)));
		send_list_op(OP_INS_AT, pick_value(), 7'd63);
		send_list_op(OP_REM_VAL, tail_value, 7'd0);
		send_list_op(OP_REM_AT, $urandom, 7'd64);
		while (mirror_len > 0) begin
			if ($urandom_range(0, 4) == 0) begin
				send_list_op(OP_FIND, pick_search_value(), 7'($urandom_range(0, 127)));
			end else begin
				send_random_remove();
			end
		end
		send_list_op(OP_REM_FRONT, $urandom, 7'($urandom_range(0, 127)));
	endtask

	initial begin
		int unsigned wait_cycles;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_corners();
		test_random_mixed(500);
		test_fill_and_drain();
		test_random_mixed(400);
		test_fill_and_drain();
		test_random_mixed(150);

		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived, first for item %0d",
				pending_results.size(), pending_results[0].item_no));
		end

		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
